### hdl/rgbhsv_pkg.sv
package rgbhsv_pkg;

	// pixel channel widths
	localparam int unsigned CH_W = 8;

	// quotient bits, one division step per cell
	localparam int unsigned QUO_W = 8;

	// hue division: dividend 255*n with n < 6*delta, divisor 6*delta pre-shifted
	localparam int unsigned HUE_REM_W = 19;
	localparam int unsigned HUE_DIV_W = 18;

	// saturation division: dividend 255*delta, divisor max pre-shifted
	localparam int unsigned SAT_REM_W = 16;
	localparam int unsigned SAT_DIV_W = 15;

	// signed hue numerator before wrapping
	localparam int unsigned NUM_W = 12;

	// data carried from one division cell to the next
	typedef struct packed {
		logic [HUE_REM_W-1:0] hue_rem;
		logic [HUE_DIV_W-1:0] hue_div;
		logic [SAT_REM_W-1:0] sat_rem;
		logic [SAT_DIV_W-1:0] sat_div;
		logic [QUO_W-1:0]     hue_quo;
		logic [QUO_W-1:0]     sat_quo;
		logic [CH_W-1:0]      value;
	} stage_t;

endpackage

### hdl/rgbhsv_pix_if.sv
interface rgbhsv_pix_if
	import rgbhsv_pkg::*;
	();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if
	import rgbhsv_pkg::*;
	();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] hue_out;
	logic [CH_W-1:0] saturation;
	logic [CH_W-1:0] brightness;

	modport source (output valid, output hue_out, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue_out, input saturation, input brightness,
		output ready);
endinterface

### hdl/rgbhsv_front.sv
module rgbhsv_front
	import rgbhsv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic            out_valid,
	input  logic            out_ready,
	output stage_t          out_data
);

	logic [CH_W-1:0]      mx;
	logic [CH_W-1:0]      mn;
	logic [CH_W-1:0]      delta;
	logic signed [NUM_W-1:0] num_raw;
	logic signed [NUM_W-1:0] num_wrap;
	logic signed [NUM_W-1:0] d_s;
	logic [NUM_W-2:0]     num;
	logic [HUE_REM_W-1:0] hue_dividend;
	logic [HUE_DIV_W-1:0] hue_divisor;
	logic [SAT_REM_W-1:0] sat_dividend;
	logic [SAT_DIV_W-1:0] sat_divisor;
	logic                 valid_s1;
	stage_t               data_s1;

	// max and min of the three channels
	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) begin
			mx = blue;
		end
		mn = (red < green) ? red : green;
		if (blue < mn) begin
			mn = blue;
		end
		delta = mx - mn;
	end

	// hue numerator by sector, ties go red then green then blue
	always_comb begin
		d_s = signed'({{(NUM_W-CH_W){1'b0}}, delta});
		if (mx == red) begin
			num_raw = signed'({{(NUM_W-CH_W){1'b0}}, green})
				- signed'({{(NUM_W-CH_W){1'b0}}, blue});
		end else if (mx == green) begin
			num_raw = (d_s <<< 1) + signed'({{(NUM_W-CH_W){1'b0}}, blue})
				- signed'({{(NUM_W-CH_W){1'b0}}, red});
		end else begin
			num_raw = (d_s <<< 2) + signed'({{(NUM_W-CH_W){1'b0}}, red})
				- signed'({{(NUM_W-CH_W){1'b0}}, green});
		end
		num_wrap = num_raw[NUM_W-1] ? (num_raw + (d_s <<< 2) + (d_s <<< 1)) : num_raw;
		num = num_wrap[NUM_W-2:0];
	end

	// dividends scaled by 255, divisors aligned to the top quotient bit
	always_comb begin
		if (delta == '0) begin
			hue_dividend = '0;
			hue_divisor  = HUE_DIV_W'(1) << (QUO_W-1);
		end else begin
			hue_dividend = {num, 8'b0} - HUE_REM_W'(num);
			hue_divisor  = (HUE_DIV_W'(delta) << (QUO_W+1)) + (HUE_DIV_W'(delta) << QUO_W);
		end
		sat_dividend = {delta, 8'b0} - SAT_REM_W'(delta);
		if (mx == '0) begin
			sat_divisor = SAT_DIV_W'(1) << (QUO_W-1);
		end else begin
			sat_divisor = SAT_DIV_W'(mx) << (QUO_W-1);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.hue_rem <= hue_dividend;
			data_s1.hue_div <= hue_divisor;
			data_s1.sat_rem <= sat_dividend;
			data_s1.sat_div <= sat_divisor;
			data_s1.hue_quo <= '0;
			data_s1.sat_quo <= '0;
			data_s1.value   <= mx;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// quotients fit in eight bits: dividend below twice the aligned divisor
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((data_s1.hue_rem < {data_s1.hue_div, 1'b0})
			&& (data_s1.sat_rem < {data_s1.sat_div, 1'b0})))
		else $error("division operand out of range");

endmodule

### hdl/rgbhsv_cell.sv
module rgbhsv_cell
	import rgbhsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stage_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output stage_t out_data
);

	logic   hue_ge;
	logic   sat_ge;
	logic   valid_q;
	stage_t data_q;
	stage_t next;

	// one restoring step on both divisions
	always_comb begin
		hue_ge = in_data.hue_rem >= HUE_REM_W'(in_data.hue_div);
		sat_ge = in_data.sat_rem >= SAT_REM_W'(in_data.sat_div);
		next.hue_rem = hue_ge ? (in_data.hue_rem - HUE_REM_W'(in_data.hue_div))
			: in_data.hue_rem;
		next.sat_rem = sat_ge ? (in_data.sat_rem - SAT_REM_W'(in_data.sat_div))
			: in_data.sat_rem;
		next.hue_div = in_data.hue_div >> 1;
		next.sat_div = in_data.sat_div >> 1;
		next.hue_quo = {in_data.hue_quo[QUO_W-2:0], hue_ge};
		next.sat_quo = {in_data.sat_quo[QUO_W-2:0], sat_ge};
		next.value   = in_data.value;
	end

	assign in_ready = !valid_q || out_ready;

	// cell occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### hdl/rgb_to_hsv_pixel.sv
// rgb to hsv conversion for 8-bit pixels
// throughput: one pixel per clock while result.ready is high; one front stage then a chain
// of eight division cells, each cell resolving one quotient bit of hue and of saturation
// reset: arst_n clears every stage valid bit; payload registers are not reset
module rgb_to_hsv_pixel
	import rgbhsv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rgbhsv_pix_if.sink   pixel,
	rgbhsv_hsv_if.source result
);

	logic   valid_c [QUO_W+1];
	logic   ready_c [QUO_W+1];
	stage_t data_c  [QUO_W+1];

	// sector select, scaling and divisor alignment
	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.red       (pixel.red),
		.green     (pixel.green),
		.blue      (pixel.blue),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_data  (data_c[0])
	);

	// division chain, most significant quotient bit first
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		rgbhsv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_data   (data_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_data  (data_c[i+1])
		);
	end

	// result word
	assign result.valid      = valid_c[QUO_W];
	assign ready_c[QUO_W]    = result.ready;
	assign result.hue_out    = data_c[QUO_W].hue_quo;
	assign result.saturation = data_c[QUO_W].sat_quo;
	assign result.brightness = data_c[QUO_W].value;

	// hue stays below a full turn
	a_hue_max: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.hue_out != 8'hff))
		else $error("hue out of range");

	// black pixel has no hue and no saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.brightness == '0))
			|-> ((result.saturation == '0) && (result.hue_out == '0)))
		else $error("black pixel with hue or saturation");

	// saturation zero exactly for grey implies hue zero
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.saturation == '0)) |-> (result.hue_out == '0))
		else $error("grey pixel with hue");

endmodule
